// ----- sv/permutation_order_mod_assert.svh -----
// Assertion macros shared by the permutation order block.
`ifndef PERMUTATION_ORDER_MOD_ASSERT_SVH
`define PERMUTATION_ORDER_MOD_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define POM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define POM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/pom_pkg.sv -----
// Shared constants, datapath commands and status for the permutation order block.
package pom_pkg;

  localparam int MAX_ELEMS_DEF = 1024;
  localparam int N_W = 11;
  localparam int IMG_W = 11;
  localparam int ORDER_W = 30;
  localparam logic [ORDER_W-1:0] MODULUS = 30'd1000000007;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_CLEAR,
    OP_ACCEPT,
    OP_FIND_A,
    OP_FIND_B,
    OP_SIZE_A,
    OP_LINK,
    OP_SCAN_START,
    OP_SCAN,
    OP_FACT_TEST,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_EXP_UPD,
    OP_LEFT_UPD,
    OP_SCAN_NEXT,
    OP_PROD_START,
    OP_PROD_CHK,
    OP_MUL_STEP,
    OP_MUL_END,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    logic union_go;
    logic item_last;
    logic cnt_done;
    logic root_hit;
    logic same_root;
    logic scan_factor;
    logic scan_last;
    logic sq_le;
    logic left_go;
    logic step_last;
    logic rem_zero;
    logic exp_zero;
    logic exp_last;
    logic k_last;
    logic out_free;
  } dp_status_t;

endpackage

// ----- sv/pom_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pom_ram #(
  parameter int W = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/pom_ctrl.sv -----
// Controller state machine that sequences union, factoring, product and clearing.
module pom_ctrl import pom_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  dp_status_t st,
  output dp_op_t     op,
  output logic       in_ready
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_FINDA, S_FINDB, S_SZA, S_LINK, S_SCAN0, S_SCAN, S_FTEST, S_DIV,
    S_DIVEND, S_EXPUPD, S_LEFT, S_SNEXT, S_PROD0, S_PCHK, S_MUL, S_MULEND, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  assign in_ready = in_ready_r;

  always_comb begin
    case (state_r)
      S_CLR:    op = OP_CLEAR;
      S_IDLE:   op = in_valid ? OP_ACCEPT : OP_NOP;
      S_FINDA:  op = OP_FIND_A;
      S_FINDB:  op = OP_FIND_B;
      S_SZA:    op = OP_SIZE_A;
      S_LINK:   op = OP_LINK;
      S_SCAN0:  op = OP_SCAN_START;
      S_SCAN:   op = OP_SCAN;
      S_FTEST:  op = OP_FACT_TEST;
      S_DIV:    op = OP_DIV_STEP;
      S_DIVEND: op = OP_DIV_END;
      S_EXPUPD: op = OP_EXP_UPD;
      S_LEFT:   op = OP_LEFT_UPD;
      S_SNEXT:  op = OP_SCAN_NEXT;
      S_PROD0:  op = OP_PROD_START;
      S_PCHK:   op = OP_PROD_CHK;
      S_MUL:    op = OP_MUL_STEP;
      S_MULEND: op = OP_MUL_END;
      S_EMIT:   op = OP_EMIT;
      default:  op = OP_NOP;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:    if (st.k_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          if (st.union_go) state_nxt = S_FINDA;
          else if (st.item_last) state_nxt = S_SCAN0;
        end
      end
      S_FINDA:  if (st.root_hit) state_nxt = S_FINDB;
      S_FINDB: begin
        if (st.root_hit) begin
          if (!st.same_root) state_nxt = S_SZA;
          else state_nxt = st.cnt_done ? S_SCAN0 : S_IDLE;
        end
      end
      S_SZA:    state_nxt = S_LINK;
      S_LINK:   state_nxt = st.cnt_done ? S_SCAN0 : S_IDLE;
      S_SCAN0:  state_nxt = S_SCAN;
      S_SCAN: begin
        if (st.scan_factor) state_nxt = S_FTEST;
        else if (st.scan_last) state_nxt = S_PROD0;
      end
      S_FTEST: begin
        if (st.sq_le) state_nxt = S_DIV;
        else if (st.left_go) state_nxt = S_LEFT;
        else state_nxt = S_SNEXT;
      end
      S_DIV:    if (st.step_last) state_nxt = S_DIVEND;
      S_DIVEND: state_nxt = st.rem_zero ? S_DIV : S_EXPUPD;
      S_EXPUPD: state_nxt = S_FTEST;
      S_LEFT:   state_nxt = S_SNEXT;
      S_SNEXT:  state_nxt = st.scan_last ? S_PROD0 : S_SCAN;
      S_PROD0:  state_nxt = S_PCHK;
      S_PCHK: begin
        if (!st.exp_zero) state_nxt = S_MUL;
        else if (st.k_last) state_nxt = S_EMIT;
      end
      S_MUL:    if (st.step_last) state_nxt = S_MULEND;
      S_MULEND: begin
        if (!st.exp_last) state_nxt = S_MUL;
        else if (st.k_last) state_nxt = S_EMIT;
        else state_nxt = S_PCHK;
      end
      S_EMIT:   if (st.out_free) state_nxt = S_CLR;
      default:  state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

endmodule

// ----- sv/pom_dp.sv -----
// Datapath with the union-find, exponent stores, trial divider and modular multiplier.
module pom_dp import pom_pkg::*; #(
  parameter int MAX_ELEMS = MAX_ELEMS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_op_t             op,
  input  logic [N_W-1:0]     n_used,
  input  logic [IMG_W-1:0]   in_img,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [ORDER_W-1:0] out_order,
  output dp_status_t         st
);

  localparam int IDX_W = $clog2(MAX_ELEMS);
  localparam int CNT_W = $clog2(MAX_ELEMS + 1);
  localparam int EXP_W = $clog2(CNT_W);
  localparam int STEP_W = $clog2(CNT_W);
  localparam int CW = ((CNT_W > N_W) ? CNT_W : N_W) + 1;
  localparam int SQ_W = 2 * CNT_W;
  localparam int PROD_W = ORDER_W + 2;

  logic             p_we, s_we, e_we;
  logic [IDX_W-1:0] p_waddr, s_waddr, e_waddr, p_raddr, s_raddr, e_raddr;
  logic [IDX_W-1:0] p_wdata, p_rdata;
  logic [CNT_W-1:0] s_wdata, s_rdata;
  logic [EXP_W-1:0] e_wdata, e_rdata;

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   k_r, k_nxt, cur_r, cur_nxt, b_r, b_nxt;
  logic [IDX_W-1:0]   ra_r, ra_nxt, rb_r, rb_nxt;
  logic [CNT_W-1:0]   sa_r, sa_nxt, len_r, len_nxt, x_r, x_nxt;
  logic [CNT_W-1:0]   quot_r, quot_nxt, rem_r, rem_nxt, mreg_r, mreg_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [EXP_W-1:0]   e_r, e_nxt;
  logic [ORDER_W-1:0] acc_r, acc_nxt, r_r, r_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ORDER_W-1:0] out_order_r, out_order_nxt;

  logic [CW-1:0]     n_ext, n_eff, img_ext, cnt_ext;
  logic [SQ_W-1:0]   x_ext, sq;
  logic [CNT_W:0]    rem_t;
  logic              rem_ge;
  logic [PROD_W-1:0] mt;
  logic              swap;
  logic [IDX_W-1:0]  k_inc;

  pom_ram #(.W(IDX_W), .DEPTH(MAX_ELEMS)) u_parent (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(p_raddr), .rdata(p_rdata)
  );
  pom_ram #(.W(CNT_W), .DEPTH(MAX_ELEMS)) u_size (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata)
  );
  pom_ram #(.W(EXP_W), .DEPTH(MAX_ELEMS)) u_exp (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata), .raddr(e_raddr), .rdata(e_rdata)
  );

  always_comb begin
    n_ext = CW'(n_used);
    if (n_ext == '0) begin
      n_eff = CW'(1);
    end else if (n_ext > CW'(MAX_ELEMS)) begin
      n_eff = CW'(MAX_ELEMS);
    end else begin
      n_eff = n_ext;
    end
    img_ext = CW'(in_img);
    cnt_ext = CW'(cnt_r);
    x_ext   = SQ_W'(x_r);
    sq      = x_ext * x_ext;
    rem_t   = {rem_r, quot_r[CNT_W-1]};
    rem_ge  = rem_t >= (CNT_W + 1)'(x_r);
    mt      = PROD_W'({r_r, 1'b0}) + (mreg_r[CNT_W-1] ? PROD_W'(acc_r) : '0);
    swap    = s_rdata > sa_r;
    k_inc   = k_r + IDX_W'(1);
  end

  always_comb begin
    st.union_go    = (cnt_ext + CW'(1) <= n_eff) && (img_ext != '0) && (img_ext <= n_eff);
    st.item_last   = (cnt_ext + CW'(1) >= n_eff);
    st.cnt_done    = (cnt_ext >= n_eff);
    st.root_hit    = (p_rdata == cur_r);
    st.same_root   = (p_rdata == cur_r) && (cur_r == ra_r);
    st.scan_factor = (p_rdata == k_r) && (s_rdata > CNT_W'(1));
    st.scan_last   = (CW'(k_r) == n_eff - CW'(1));
    st.sq_le       = (sq <= SQ_W'(len_r));
    st.left_go     = (len_r > CNT_W'(1));
    st.step_last   = (step_r == STEP_W'(CNT_W - 1));
    st.rem_zero    = (rem_r == '0);
    st.exp_zero    = (e_rdata == '0);
    st.exp_last    = (e_r == EXP_W'(1));
    st.k_last      = (k_r == IDX_W'(MAX_ELEMS - 1));
    st.out_free    = !out_valid_r || out_ready;
  end

  always_comb begin
    cnt_nxt = cnt_r;  k_nxt = k_r;  cur_nxt = cur_r;  b_nxt = b_r;
    ra_nxt = ra_r;  rb_nxt = rb_r;  sa_nxt = sa_r;  len_nxt = len_r;  x_nxt = x_r;
    quot_nxt = quot_r;  rem_nxt = rem_r;  mreg_nxt = mreg_r;  step_nxt = step_r;
    e_nxt = e_r;  acc_nxt = acc_r;  r_nxt = r_r;
    out_order_nxt = out_order_r;
    out_valid_nxt = (out_valid_r && !out_ready);
    p_we = 1'b0;  p_waddr = k_r;  p_wdata = k_r;  p_raddr = '0;
    s_we = 1'b0;  s_waddr = k_r;  s_wdata = CNT_W'(1);  s_raddr = '0;
    e_we = 1'b0;  e_waddr = k_r;  e_wdata = '0;  e_raddr = '0;
    case (op)
      OP_CLEAR: begin
        p_we = 1'b1;
        s_we = 1'b1;
        e_we = 1'b1;
        k_nxt = st.k_last ? '0 : k_inc;
      end
      OP_ACCEPT: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        cur_nxt = cnt_r[IDX_W-1:0];
        b_nxt   = IDX_W'(img_ext - CW'(1));
        p_raddr = cnt_r[IDX_W-1:0];
      end
      OP_FIND_A: begin
        if (st.root_hit) begin
          ra_nxt  = cur_r;
          cur_nxt = b_r;
          p_raddr = b_r;
        end else begin
          cur_nxt = p_rdata;
          p_raddr = p_rdata;
        end
      end
      OP_FIND_B: begin
        if (st.root_hit) begin
          rb_nxt  = cur_r;
          s_raddr = ra_r;
        end else begin
          cur_nxt = p_rdata;
          p_raddr = p_rdata;
        end
      end
      OP_SIZE_A: begin
        sa_nxt  = s_rdata;
        s_raddr = rb_r;
      end
      OP_LINK: begin
        p_we    = 1'b1;
        p_waddr = swap ? ra_r : rb_r;
        p_wdata = swap ? rb_r : ra_r;
        s_we    = 1'b1;
        s_waddr = swap ? rb_r : ra_r;
        s_wdata = sa_r + s_rdata;
      end
      OP_SCAN_START: begin
        k_nxt = '0;
      end
      OP_SCAN: begin
        if (st.scan_factor) begin
          len_nxt = s_rdata;
          x_nxt   = CNT_W'(2);
        end else if (!st.scan_last) begin
          k_nxt   = k_inc;
          p_raddr = k_inc;
          s_raddr = k_inc;
        end
      end
      OP_FACT_TEST: begin
        quot_nxt = len_r;
        rem_nxt  = '0;
        step_nxt = '0;
        e_nxt    = '0;
        e_raddr  = IDX_W'(len_r - CNT_W'(1));
      end
      OP_DIV_STEP: begin
        quot_nxt = {quot_r[CNT_W-2:0], rem_ge};
        rem_nxt  = rem_ge ? CNT_W'(rem_t - (CNT_W + 1)'(x_r)) : rem_t[CNT_W-1:0];
        step_nxt = step_r + STEP_W'(1);
      end
      OP_DIV_END: begin
        if (st.rem_zero) begin
          len_nxt  = quot_r;
          rem_nxt  = '0;
          step_nxt = '0;
          e_nxt    = e_r + EXP_W'(1);
        end else begin
          e_raddr = IDX_W'(x_r - CNT_W'(1));
        end
      end
      OP_EXP_UPD: begin
        e_waddr = IDX_W'(x_r - CNT_W'(1));
        e_wdata = e_r;
        e_we    = (e_r > e_rdata);
        x_nxt   = x_r + CNT_W'(1);
      end
      OP_LEFT_UPD: begin
        e_waddr = IDX_W'(len_r - CNT_W'(1));
        e_wdata = EXP_W'(1);
        e_we    = st.exp_zero;
      end
      OP_SCAN_NEXT: begin
        if (!st.scan_last) begin
          k_nxt   = k_inc;
          p_raddr = k_inc;
          s_raddr = k_inc;
        end
      end
      OP_PROD_START: begin
        acc_nxt = ORDER_W'(1);
        k_nxt   = IDX_W'(1);
        e_raddr = IDX_W'(1);
      end
      OP_PROD_CHK: begin
        if (!st.exp_zero) begin
          e_nxt    = e_rdata;
          r_nxt    = '0;
          step_nxt = '0;
          mreg_nxt = CNT_W'(k_r) + CNT_W'(1);
        end else if (!st.k_last) begin
          k_nxt   = k_inc;
          e_raddr = k_inc;
        end
      end
      OP_MUL_STEP: begin
        if (mt >= (PROD_W'(MODULUS) << 1)) begin
          r_nxt = ORDER_W'(mt - (PROD_W'(MODULUS) << 1));
        end else if (mt >= PROD_W'(MODULUS)) begin
          r_nxt = ORDER_W'(mt - PROD_W'(MODULUS));
        end else begin
          r_nxt = ORDER_W'(mt);
        end
        mreg_nxt = mreg_r << 1;
        step_nxt = step_r + STEP_W'(1);
      end
      OP_MUL_END: begin
        acc_nxt = r_r;
        if (!st.exp_last) begin
          e_nxt    = e_r - EXP_W'(1);
          r_nxt    = '0;
          step_nxt = '0;
          mreg_nxt = CNT_W'(k_r) + CNT_W'(1);
        end else if (!st.k_last) begin
          k_nxt   = k_inc;
          e_raddr = k_inc;
        end
      end
      OP_EMIT: begin
        if (st.out_free) begin
          out_valid_nxt = 1'b1;
          out_order_nxt = acc_r;
          k_nxt         = '0;
          cnt_nxt       = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r <= cur_nxt;  b_r <= b_nxt;  ra_r <= ra_nxt;  rb_r <= rb_nxt;
    sa_r <= sa_nxt;  len_r <= len_nxt;  x_r <= x_nxt;
    quot_r <= quot_nxt;  rem_r <= rem_nxt;  mreg_r <= mreg_nxt;  step_r <= step_nxt;
    e_r <= e_nxt;  acc_r <= acc_nxt;  r_r <= r_nxt;  out_order_r <= out_order_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_order = out_order_r;

endmodule

// ----- sv/permutation_order_mod.sv -----
// Top level of the permutation order block: ports, configuration register and assertions.
// The input stream carries the one-based images of positions 1..n_used, one per item.
// Each item merges its position with its image in a union-find store in RAM (union by
// size). An item with no merge leaves the store unchanged; a merge walks the parent
// links from the position and from the image to their roots and, if the roots differ,
// links the smaller set's root under the other. After the last position the block scans
// the n_used positions for roots, factors each cycle length by trial division with an
// 11-step serial divider, then walks the exponent entries for 2..MAX_ELEMS and multiplies
// in each prime power with an 11-step serial modular multiplier. The result item carries
// the LCM of the cycle lengths modulo 1000000007. After each result, and after reset,
// a clearing pass over all MAX_ELEMS entries rewrites the three stores; in_tready
// stays low during it. A result waits in an output register while out_tready is low;
// the clearing pass runs meanwhile, and the next result is held until the register is
// free. n_used is written through the configuration port at address 0 while idle;
// the user must keep to this, as the block does not enforce it.
module permutation_order_mod import pom_pkg::*; #(
  parameter int MAX_ELEMS = MAX_ELEMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [10:0] image_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [29:0] order_mod
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  `include "permutation_order_mod_assert.svh"

  logic [N_W-1:0]     n_used_r;
  dp_op_t             op;
  dp_status_t         st;
  logic [ORDER_W-1:0] order;
  logic               union_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_used_r <= N_W'(1);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2]) begin
      n_used_r <= cfg_pwdata[N_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? '0 : 32'(n_used_r);

  pom_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .st(st), .op(op), .in_ready(in_tready)
  );

  pom_dp #(.MAX_ELEMS(MAX_ELEMS)) u_dp (
    .clk(clk), .rst_n(rst_n), .op(op), .n_used(n_used_r), .in_img(in_tdata[IMG_W-1:0]),
    .out_ready(out_tready), .out_valid(out_tvalid), .out_order(order), .st(st)
  );

  assign out_tdata = 32'(order);
  assign union_acc = in_tvalid && in_tready && st.union_go;

  `POM_ASSERT_NOW(a_result_starts_clear, $rose(out_tvalid), !in_tready, "input open at result")
  `POM_ASSERT_NEXT(a_union_blocks_input, union_acc, !in_tready, "input open in union")

endmodule

// ----- bench/testbench.sv -----
// Testbench for the permutation order block: directed and random permutations checked
// against an in-bench union-find and LCM predictor.
`timescale 1ns / 100ps

module testbench;
  import pom_pkg::*;

  localparam int NMAX = MAX_ELEMS_DEF;
  localparam longint unsigned MODV = 64'd1000000007;
  localparam logic [2:0] ADDR_N_USED = 3'd0;
  localparam int LIMIT_CYCLES = 30000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  permutation_order_mod u_top (.*);

  always #5 clk = ~clk;

  int unsigned parent_of [1:NMAX];
  int unsigned size_of [1:NMAX];
  int unsigned exp_of [1:NMAX];
  int unsigned taken;
  int unsigned n_reg;
  logic [ORDER_W-1:0] order_queue [$];
  int errors = 0;
  int cycles = 0;
  bit quiet_rx = 1'b0;
  bit hold_rx = 1'b0;
  bit busy_rx = 1'b0;
  int items_in = 0;

  function automatic int unsigned find_root(int unsigned node);
    int unsigned r;
    int unsigned nxt;
    r = node;
    while (parent_of[r] != r) r = parent_of[r];
    while (node != r) begin
      nxt = parent_of[node];
      parent_of[node] = r;
      node = nxt;
    end
    return r;
  endfunction

  function automatic void clear_sets();
    for (int k = 1; k <= NMAX; k++) begin
      parent_of[k] = k;
      size_of[k] = 1;
      exp_of[k] = 0;
    end
    taken = 0;
  endfunction

  function automatic void add_factors(int unsigned len);
    int unsigned e;
    for (int unsigned x = 2; x * x <= len; x++) begin
      e = 0;
      while (len % x == 0) begin
        len = len / x;
        e++;
      end
      if (e > exp_of[x]) exp_of[x] = e;
    end
    if (len > 1 && exp_of[len] < 1) exp_of[len] = 1;
  endfunction

  // Applies one image and queues the order when the permutation completes.
  function automatic void predict_image(int unsigned img);
    int unsigned n;
    int unsigned pos;
    int unsigned ra;
    int unsigned rb;
    int unsigned t;
    longint unsigned acc;
    n = n_reg;
    if (n < 1) n = 1;
    if (n > NMAX) n = NMAX;
    pos = taken + 1;
    if (pos <= n && img >= 1 && img <= n) begin
      ra = find_root(pos);
      rb = find_root(img);
      if (ra != rb) begin
        if (size_of[rb] > size_of[ra]) begin
          t = ra; ra = rb; rb = t;
        end
        parent_of[rb] = ra;
        size_of[ra] += size_of[rb];
      end
    end
    taken = pos;
    if (taken >= n) begin
      for (int unsigned k = 1; k <= n; k++)
        if (find_root(k) == k) add_factors(size_of[k]);
      acc = 1;
      for (int k = 2; k <= NMAX; k++)
        for (int e = 0; e < exp_of[k]; e++) acc = (acc * k) % MODV;
      order_queue.insert(order_queue.size(), acc[ORDER_W-1:0]);
      clear_sets();
    end
  endfunction

  task automatic send_image(int unsigned img);
    while (!quiet_rx && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= 16'(img[10:0]);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_image(img);
    items_in++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (order_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_n_used(int unsigned val);
    wait_drained();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_N_USED;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    n_reg = val & 32'h7ff;
  endtask

  // Sends a random permutation of 1..n, with an occasional broken image when noisy is set.
  task automatic send_perm(int unsigned n, bit noisy);
    int unsigned perm [];
    int unsigned j;
    int unsigned t;
    perm = new[n];
    for (int k = 0; k < n; k++) perm[k] = k + 1;
    for (int k = n - 1; k > 0; k--) begin
      j = $urandom_range(k);
      t = perm[k]; perm[k] = perm[j]; perm[j] = t;
    end
    for (int k = 0; k < n; k++) begin
      if (noisy && $urandom_range(19) == 0) send_image($urandom_range(2047));
      else send_image(perm[k]);
    end
  endtask

  typedef struct {
    int unsigned n_set;
    int unsigned img;
    bit has_order;
    logic [ORDER_W-1:0] order_val;
  } image_row_t;

  // Rows with n_set of zero leave the register as it is.
  image_row_t image_rows [] = '{
    '{0, 1, 1, 30'd1},
    '{0, 2047, 1, 30'd1},
    '{0, 0, 1, 30'd1},
    '{2, 2, 0, 0}, '{0, 1, 1, 30'd2},
    '{0, 1, 0, 0}, '{0, 2, 1, 30'd1},
    '{0, 0, 0, 0}, '{0, 1024, 1, 30'd1},
    '{3, 2, 0, 0}, '{0, 3, 0, 0}, '{0, 1, 1, 30'd3},
    '{6, 2, 0, 0}, '{0, 1, 0, 0}, '{0, 4, 0, 0}, '{0, 5, 0, 0}, '{0, 6, 0, 0},
    '{0, 3, 1, 30'd4},
    '{2047, 1, 0, 0}, '{0, 0, 0, 0}, '{0, 3, 0, 0}
  };

  initial begin : stim
    n_reg = 1;
    clear_sets();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (image_rows[i]) begin
      if (image_rows[i].n_set != 0) write_n_used(image_rows[i].n_set);
      send_image(image_rows[i].img);
      if (image_rows[i].has_order && order_queue.size() != 0 &&
          order_queue[$] != image_rows[i].order_val) begin
        $display("%0t table row %0d: expected %0d actual %0d", $time, i,
                 image_rows[i].order_val, order_queue[$]);
        errors++;
      end
    end
    // Lowering the register mid-permutation makes the next image end it.
    write_n_used(0);
    send_image(5);
    write_n_used(1025);
    send_perm(1024, 1'b0);
    write_n_used(4);
    hold_rx <= 1'b1;
    repeat (4) send_perm(4, 1'b0);
    wait_drained();
    write_n_used(16);
    quiet_rx = 1'b1;
    repeat (8) send_perm(16, 1'b0);
    quiet_rx = 1'b0;
    while (items_in < 1900) begin
      write_n_used($urandom_range(9) == 0 ? 0 : $urandom_range(1, 40));
      repeat ($urandom_range(1, 4)) send_perm(n_reg < 1 ? 1 : n_reg, $urandom_range(3) == 0);
    end
    wait_drained();
    if (errors == 0) begin
      $display("[permutation_order_mod] OK");
    end else begin
      $display("[permutation_order_mod] ERROR");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (hold_rx) begin
      if (!busy_rx) begin
        busy_rx <= 1'b1;
        out_tready <= 1'b0;
      end
    end else begin
      out_tready <= quiet_rx ? 1'b1 : ($urandom_range(99) >= 18);
    end
  end

  initial begin : stall_rx
    forever begin
      @(posedge clk);
      if (busy_rx) begin
        repeat (20000) @(posedge clk);
        hold_rx <= 1'b0;
        busy_rx <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (order_queue.size() == 0) begin
        $display("%0t unexpected order: actual %0d", $time, out_tdata[ORDER_W-1:0]);
        errors++;
      end else if (order_queue[0] != out_tdata[ORDER_W-1:0]) begin
        $display("%0t order mismatch: expected %0d actual %0d", $time, order_queue[0],
                 out_tdata[ORDER_W-1:0]);
        errors++;
        void'(order_queue.pop_front());
      end else begin
        void'(order_queue.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("[permutation_order_mod] ERROR");
      $finish;
    end
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/pom_pkg.sv
sv/pom_ram.sv
sv/pom_ctrl.sv
sv/pom_dp.sv
sv/permutation_order_mod.sv
bench/testbench.sv
